### sv/isgb_pkg.sv
`default_nettype none

package isgb_pkg;

  localparam int CAL_SAMPLES_LOG2 = 9;
  localparam int RECIP_FRAC_BITS  = 20;

  localparam int RAW_W   = 16;
  localparam int AXIS_W  = 19;
  localparam int OFF_W   = 8;
  localparam int SUM_W   = 26;
  localparam int RANGE_W = 2;
  localparam int IDX_W   = 8;
  localparam int CNT_W   = CAL_SAMPLES_LOG2;
  localparam int RECIP_W = RECIP_FRAC_BITS - 4;
  localparam int PROD_W  = RAW_W + RECIP_W + 1;
  localparam int ACC_W   = RECIP_FRAC_BITS + 14;

  localparam logic [IDX_W-1:0] CFG_GYRO_RANGE  = IDX_W'(0);
  localparam logic [IDX_W-1:0] CFG_ACCEL_RANGE = IDX_W'(1);

  typedef enum logic [1:0] {
    OP_GYRO  = 2'd0,
    OP_ACCEL = 2'd1,
    OP_CAL   = 2'd2
  } opcode_t;

  localparam longint unsigned RECIP_NUM = (64'd1 << RECIP_FRAC_BITS) * 64'd10;
  localparam longint unsigned RECIP_0   = (RECIP_NUM + 64'd655) / 64'd1310;
  localparam longint unsigned RECIP_1   = (RECIP_NUM + 64'd327) / 64'd655;
  localparam longint unsigned RECIP_2   = (RECIP_NUM + 64'd164) / 64'd328;
  localparam longint unsigned RECIP_3   = (RECIP_NUM + 64'd82) / 64'd164;

  typedef logic [RECIP_W-1:0] recip_t;

  function automatic recip_t gyro_recip(input logic [RANGE_W-1:0] range);
    recip_t r;
    case (range)
      2'd0:    r = RECIP_W'(RECIP_0);
      2'd1:    r = RECIP_W'(RECIP_1);
      2'd2:    r = RECIP_W'(RECIP_2);
      default: r = RECIP_W'(RECIP_3);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/imu_sample_scale_and_gyro_bias_cal_unit.sv
// An accepted input request passes through the input register, then the result register,
// before its result is valid on the master side.
// Throughput: one request per cycle unless m_tready stalls; input and result registers,
// state (offsets, sums, count) updated as a request moves into the result register.
// Reset (rst, synchronous): ranges, offsets, sums and count cleared, both stages empty.
`default_nettype none

module imu_sample_scale_and_gyro_bias_cal_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // x_high, x_low, y_high, y_low, z_high, z_low
  input  wire logic [47:0] s_tdata,
  // opcode
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // axis_x, axis_y, axis_z, cal_done, offset_x, offset_y, offset_z, zero pad
  output logic [87:0]      m_tdata,
  // kind
  output logic [1:0]       m_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [isgb_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [isgb_pkg::RANGE_W-1:0] cfg_data
);

  localparam int AW = isgb_pkg::AXIS_W;
  localparam int OW = isgb_pkg::OFF_W;
  localparam int SW = isgb_pkg::SUM_W;
  localparam int L  = isgb_pkg::CAL_SAMPLES_LOG2;

  logic [isgb_pkg::RANGE_W-1:0] gyro_fs_sel;
  logic [isgb_pkg::RANGE_W-1:0] accel_fs_sel;

  logic                                 s1_valid;
  logic [1:0]                           s1_op;
  logic signed [isgb_pkg::RAW_W-1:0]    s1_raw [3];

  logic signed [OW-1:0]       gyro_offsets [3];
  logic signed [OW-1:0]       gyro_offsets_next [3];
  logic signed [SW-1:0]       cal_sums [3];
  logic signed [SW-1:0]       cal_sums_next [3];
  logic [isgb_pkg::CNT_W-1:0] cal_count;
  logic [isgb_pkg::CNT_W-1:0] cal_count_next;

  logic                out_valid;
  logic [1:0]          out_kind;
  logic signed [AW-1:0] out_axis [3];
  logic                out_done;
  logic signed [OW-1:0] out_off [3];

  logic                 out_free;
  logic                 s1_fire;
  logic                 in_fire;
  isgb_pkg::recip_t     recip;
  logic signed [AW-1:0] gyro_axis [3];
  logic signed [AW-1:0] axis_next [3];
  logic                 done_next;
  logic signed [SW-1:0] new_sum [3];
  logic [SW-1:0]        mag [3];
  logic [SW:0]          q [3];

  assign out_free  = !out_valid || m_tready;
  assign s1_fire   = s1_valid && out_free;
  assign s_tready  = !s1_valid || out_free;
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign recip     = isgb_pkg::gyro_recip(gyro_fs_sel);

  for (genvar g = 0; g < 3; g++) begin : g_axis
    isgb_gyro_scale u_scale (
      .raw    (s1_raw[g]),
      .recip  (recip),
      .offset (gyro_offsets[g]),
      .axis   (gyro_axis[g])
    );
  end

  always_comb begin
    done_next      = 1'b0;
    cal_count_next = cal_count;
    for (int i = 0; i < 3; i++) begin
      axis_next[i]         = '0;
      gyro_offsets_next[i] = gyro_offsets[i];
      cal_sums_next[i]     = cal_sums[i];
      new_sum[i]           = cal_sums[i] + SW'(gyro_axis[i]);
      mag[i]               = new_sum[i][SW-1] ? SW'(-new_sum[i]) : SW'(new_sum[i]);
      q[i]                 = ({1'b0, mag[i]} + (SW+1)'(64'd1 << (L - 1))) >> L;
    end
    case (s1_op)
      isgb_pkg::OP_GYRO: begin
        for (int i = 0; i < 3; i++) axis_next[i] = gyro_axis[i];
      end
      isgb_pkg::OP_ACCEL: begin
        for (int i = 0; i < 3; i++) axis_next[i] = AW'(s1_raw[i]) <<< accel_fs_sel;
      end
      isgb_pkg::OP_CAL: begin
        for (int i = 0; i < 3; i++) begin
          axis_next[i]     = gyro_axis[i];
          cal_sums_next[i] = new_sum[i];
        end
        cal_count_next = cal_count + 1'b1;
        if (&cal_count) begin
          done_next = 1'b1;
          for (int i = 0; i < 3; i++) begin
            cal_sums_next[i] = '0;
            // negated mean, saturated
            if (!new_sum[i][SW-1] && (new_sum[i] != '0)) begin
              gyro_offsets_next[i] = (q[i] > (SW+1)'(128)) ? OW'(-128) : OW'(-q[i]);
            end else begin
              gyro_offsets_next[i] = (q[i] > (SW+1)'(127)) ? OW'(127) : OW'(q[i]);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_fs_sel  <= '0;
      accel_fs_sel <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == isgb_pkg::CFG_GYRO_RANGE) gyro_fs_sel <= cfg_data;
      if (cfg_index == isgb_pkg::CFG_ACCEL_RANGE) accel_fs_sel <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
    if (in_fire) begin
      s1_op     <= s_tuser;
      s1_raw[0] <= {s_tdata[7:0], s_tdata[15:8]};
      s1_raw[1] <= {s_tdata[23:16], s_tdata[31:24]};
      s1_raw[2] <= {s_tdata[39:32], s_tdata[47:40]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_count <= '0;
      for (int i = 0; i < 3; i++) begin
        gyro_offsets[i] <= '0;
        cal_sums[i]     <= '0;
      end
    end else if (s1_fire) begin
      cal_count <= cal_count_next;
      for (int i = 0; i < 3; i++) begin
        gyro_offsets[i] <= gyro_offsets_next[i];
        cal_sums[i]     <= cal_sums_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
    if (s1_fire) begin
      out_kind <= s1_op;
      out_done <= done_next;
      for (int i = 0; i < 3; i++) begin
        out_axis[i] <= axis_next[i];
        out_off[i]  <= gyro_offsets_next[i];
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {6'd0, out_off[2], out_off[1], out_off[0], out_done,
                     out_axis[2], out_axis[1], out_axis[0]};

endmodule

`default_nettype wire

### sv/isgb_gyro_scale.sv
`default_nettype none

module isgb_gyro_scale (
  input  wire logic signed [isgb_pkg::RAW_W-1:0]  raw,
  input  wire isgb_pkg::recip_t                   recip,
  input  wire logic signed [isgb_pkg::OFF_W-1:0]  offset,
  output logic signed [isgb_pkg::AXIS_W-1:0]      axis
);

  logic signed [isgb_pkg::PROD_W-1:0] prod;
  logic signed [isgb_pkg::ACC_W-1:0]  acc;
  logic signed [isgb_pkg::ACC_W-1:0]  bias;
  logic signed [isgb_pkg::ACC_W-1:0]  adj;
  logic signed [isgb_pkg::ACC_W-1:0]  shifted;

  always_comb begin
    prod    = isgb_pkg::PROD_W'(raw) * $signed({1'b0, recip});
    acc     = isgb_pkg::ACC_W'(prod)
            + (isgb_pkg::ACC_W'(offset) <<< isgb_pkg::RECIP_FRAC_BITS);
    // truncate toward zero
    bias    = acc[isgb_pkg::ACC_W-1]
            ? isgb_pkg::ACC_W'((64'd1 << isgb_pkg::RECIP_FRAC_BITS) - 64'd1)
            : '0;
    adj     = acc + bias;
    shifted = adj >>> isgb_pkg::RECIP_FRAC_BITS;
    axis    = shifted[isgb_pkg::AXIS_W-1:0];
  end

endmodule

`default_nettype wire
